/* src/afba_pkg.sv */
package afba_pkg;

    localparam int unsigned SAMPLE_WIDTH      = 16;
    localparam int unsigned MAX_AVERAGE_COUNT = 255;

    localparam int unsigned BYTE_WIDTH  = 8;
    localparam int unsigned FRAME_WIDTH = 3 * BYTE_WIDTH;
    localparam int unsigned OUT_WIDTH   = 16;
    localparam int unsigned SUM_WIDTH   = 24;
    localparam int unsigned CNT_WIDTH   = 8;
    localparam int unsigned DIV_STEPS   = SUM_WIDTH;
    localparam int unsigned STEP_WIDTH  = $clog2(DIV_STEPS);

    localparam logic [OUT_WIDTH-1:0] SAMPLE_MASK =
        OUT_WIDTH'((64'd1 << SAMPLE_WIDTH) - 64'd1);
    localparam logic [CNT_WIDTH-1:0] COUNT_RESET = CNT_WIDTH'(1);
    localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic accum;
        logic start;
        logic step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic close_hit;
        logic out_free;
    } status_t;

    function automatic logic [CNT_WIDTH-1:0] effective_count(input logic [CNT_WIDTH-1:0] c);
        logic [CNT_WIDTH-1:0] r;
        r = c;
        if (r == '0) begin
            r = CNT_WIDTH'(1);
        end
        if (32'(r) > MAX_AVERAGE_COUNT) begin
            r = CNT_WIDTH'(MAX_AVERAGE_COUNT);
        end
        return r;
    endfunction

endpackage

/* src/afba_ctrl.sv */
module afba_ctrl
    import afba_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t                state_reg, state_next;
    logic [STEP_WIDTH-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (status.close_hit) begin
                        cmd.start  = 1'b1;
                        step_next  = '0;
                        state_next = ST_DIV;
                    end else begin
                        cmd.accum = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                cmd.step  = 1'b1;
                step_next = step_reg + STEP_WIDTH'(1);
                if (step_reg == STEP_LAST) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/afba_datapath.sv */
module afba_datapath
    import afba_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [FRAME_WIDTH-1:0] s_tdata,
    input  logic                   s_tuser,
    input  logic                   cfg_valid,
    input  logic [CNT_WIDTH-1:0]   cfg_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_WIDTH-1:0]   m_tdata,
    input  cmd_t                   cmd,
    output status_t                status
);

    logic [CNT_WIDTH-1:0] count_reg;
    logic [SUM_WIDTH-1:0] sum_reg;
    logic [CNT_WIDTH-1:0] taken_reg;
    logic [CNT_WIDTH-1:0] divisor_reg;
    logic [CNT_WIDTH-1:0] rem_reg;
    logic [SUM_WIDTH-1:0] quot_reg;
    logic [OUT_WIDTH-1:0] out_reg;
    logic                 out_valid_reg;

    logic [OUT_WIDTH-1:0] sample;
    logic [SUM_WIDTH:0]   sum_wide;
    logic [SUM_WIDTH-1:0] sum_next;
    logic [CNT_WIDTH:0]   taken_next;
    logic [CNT_WIDTH-1:0] count_eff;
    logic [CNT_WIDTH:0]   rem_shift;
    logic [CNT_WIDTH:0]   rem_diff;
    logic                 rem_ge;
    logic [OUT_WIDTH-1:0] quot_sat;

    always_comb begin
        if (s_tuser) begin
            sample = {s_tdata[BYTE_WIDTH-2:0], s_tdata[2*BYTE_WIDTH-1:BYTE_WIDTH],
                      s_tdata[FRAME_WIDTH-1]} & SAMPLE_MASK;
        end else begin
            sample = '0;
        end
        sum_wide   = {1'b0, sum_reg} + (SUM_WIDTH+1)'(sample);
        sum_next   = sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
        taken_next = {1'b0, taken_reg} + (CNT_WIDTH+1)'(1);
        count_eff  = effective_count(count_reg);
        status.close_hit = taken_next >= {1'b0, count_eff};
        status.out_free  = !out_valid_reg || m_tready;

        rem_shift = {rem_reg, quot_reg[SUM_WIDTH-1]};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
        rem_ge    = rem_shift >= {1'b0, divisor_reg};

        if (quot_reg[SUM_WIDTH-1:OUT_WIDTH] != '0) begin
            quot_sat = '1;
        end else begin
            quot_sat = quot_reg[OUT_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= COUNT_RESET;
            sum_reg       <= '0;
            taken_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                count_reg <= cfg_data;
            end
            if (cmd.accum) begin
                sum_reg   <= sum_next;
                taken_reg <= taken_next[CNT_WIDTH-1:0];
            end else if (cmd.start) begin
                sum_reg   <= '0;
                taken_reg <= '0;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            divisor_reg <= count_eff;
            rem_reg     <= '0;
            quot_reg    <= sum_next;
        end else if (cmd.step) begin
            rem_reg  <= rem_ge ? rem_diff[CNT_WIDTH-1:0] : rem_shift[CNT_WIDTH-1:0];
            quot_reg <= {quot_reg[SUM_WIDTH-2:0], rem_ge};
        end
        if (cmd.load_out) begin
            out_reg <= quot_sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

/* src/adc_frame_block_averager_top.sv */
// Boxcar average decimator for three-byte serial ADC frames. Each input beat
// carries one raw frame; the 16-bit sample is bits 6..0 of the first byte,
// the middle byte and bit 7 of the last byte, or zero when tuser flags a failed
// transfer. Samples are summed (saturating at 24 bits); when the number taken
// reaches the average count (cfg_data, reset 1, 0 acts as 1) one output beat
// carries the truncated mean, saturated to 16 bits, and the sum is cleared.
// A beat that does not close a block is accepted and summed. A closing beat is
// accepted, then the restoring divider yields one quotient bit per cycle, then
// the output register is loaded once it is free; s_tready stays low meanwhile.
// The count may only be written while no block is being divided.
module adc_frame_block_averager_top
    import afba_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // frame_byte_first [7:0], frame_byte_middle [15:8], frame_byte_last [23:16]
    input  logic [FRAME_WIDTH-1:0] s_tdata,
    // transfer_ok [0]
    input  logic                   s_tuser,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // averaged_sample [15:0]
    output logic [OUT_WIDTH-1:0]   m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // average_count [7:0]
    input  logic [CNT_WIDTH-1:0]   cfg_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    afba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    afba_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
